// ===== design/nnk_pkg.sv =====
// nnk_pkg: shared constants, request codes and control structs for the
// newest-n keeper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nnk_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAMP_W  = 32;
  localparam int TAG_W    = 16;
  localparam int KEEP_W   = 6;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd20;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_OFFER = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  // control broadcast from the sequencer to the row of cells
  typedef struct packed {
    cell_op_t             op;
    logic [STAMP_W-1:0]   stamp;
    logic [TAG_W-1:0]     tag;
    logic [CNT_W-1:0]     count;
  } chain_ctl_t;

  // summary from the row back to the sequencer
  typedef struct packed {
    logic                 dup;
    logic [STAMP_W-1:0]   oldest;
    logic [STAMP_W-1:0]   head_stamp;
    logic [TAG_W-1:0]     head_tag;
  } chain_stat_t;

endpackage
`default_nettype wire

// ===== design/nnk_cell.sv =====
// nnk_cell: one slot of the sorted row; holds a stamp and tag and
// shifts toward or from its neighbors. Depends on nnk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nnk_cell (
  input  wire logic                          clk,
  input  wire nnk_pkg::chain_ctl_t           ctl,
  input  wire logic                          occ,
  input  wire logic                          tail,
  input  wire logic                          prev_gt,
  input  wire logic [nnk_pkg::STAMP_W-1:0]   left_stamp,
  input  wire logic [nnk_pkg::TAG_W-1:0]     left_tag,
  input  wire logic [nnk_pkg::STAMP_W-1:0]   right_stamp,
  input  wire logic [nnk_pkg::TAG_W-1:0]     right_tag,
  input  wire logic [nnk_pkg::STAMP_W-1:0]   head_stamp,
  input  wire logic [nnk_pkg::TAG_W-1:0]     head_tag,
  output logic [nnk_pkg::STAMP_W-1:0]        stamp,
  output logic [nnk_pkg::TAG_W-1:0]          tag,
  output logic                               gt,
  output logic                               eq
);

  assign gt = occ && (stamp > ctl.stamp);
  assign eq = occ && (stamp == ctl.stamp);

  always_ff @(posedge clk) begin
    case (ctl.op)
      nnk_pkg::OP_INSERT: begin
        // newer entries stay, the slot at the insert point takes the new
        // word, everything older moves down one
        if (!gt) begin
          if (prev_gt) begin
            stamp <= ctl.stamp;
            tag   <= ctl.tag;
          end else begin
            stamp <= left_stamp;
            tag   <= left_tag;
          end
        end
      end
      nnk_pkg::OP_ROTATE: begin
        // readout: row moves up, head wraps into the tail slot
        if (tail) begin
          stamp <= head_stamp;
          tag   <= head_tag;
        end else begin
          stamp <= right_stamp;
          tag   <= right_tag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/nnk_chain.sv =====
// nnk_chain: row of CAPACITY cells with occupancy from the fill count,
// duplicate detect and oldest-entry select. Depends on nnk_pkg, nnk_cell.
`timescale 1ns / 1ps
`default_nettype none
module nnk_chain (
  input  wire logic                 clk,
  input  wire nnk_pkg::chain_ctl_t  ctl,
  output nnk_pkg::chain_stat_t      stat
);

  localparam int N = nnk_pkg::CAPACITY;

  logic [nnk_pkg::STAMP_W-1:0] stamps [N];
  logic [nnk_pkg::TAG_W-1:0]   tags   [N];
  logic [N-1:0]                occ, tail, gt, eq;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic                         pg;
      logic [nnk_pkg::STAMP_W-1:0]  ls, rs;
      logic [nnk_pkg::TAG_W-1:0]    lt, rt;

      assign occ[i]  = ctl.count > nnk_pkg::CNT_W'(i);
      assign tail[i] = ctl.count == nnk_pkg::CNT_W'(i + 1);

      if (i == 0) begin : g_first
        assign pg = 1'b1;
        assign ls = ctl.stamp;
        assign lt = ctl.tag;
      end else begin : g_mid
        assign pg = gt[i-1];
        assign ls = stamps[i-1];
        assign lt = tags[i-1];
      end

      if (i == N - 1) begin : g_end
        assign rs = stamps[0];
        assign rt = tags[0];
      end else begin : g_inner
        assign rs = stamps[i+1];
        assign rt = tags[i+1];
      end

      nnk_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ[i]),
        .tail        (tail[i]),
        .prev_gt     (pg),
        .left_stamp  (ls),
        .left_tag    (lt),
        .right_stamp (rs),
        .right_tag   (rt),
        .head_stamp  (stamps[0]),
        .head_tag    (tags[0]),
        .stamp       (stamps[i]),
        .tag         (tags[i]),
        .gt          (gt[i]),
        .eq          (eq[i])
      );
    end
  endgenerate

  // tail is one-hot or empty, so an OR picks the oldest stamp (0 if empty)
  always_comb begin
    stat.oldest = '0;
    for (int k = 0; k < N; k++) begin
      if (tail[k]) stat.oldest = stat.oldest | stamps[k];
    end
    stat.dup        = |eq;
    stat.head_stamp = stamps[0];
    stat.head_tag   = tags[0];
  end

endmodule
`default_nettype wire

// ===== design/newest_n_keeper_top.sv =====
// newest_n_keeper_top: stream wrapper, request sequencer and output
// register around the sorted cell row. Depends on nnk_pkg, nnk_chain.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tuser: req_type; tdata: stamp, item_tag
//  m_*     | out | m_tvalid/m_tready  | tuser: prune, bad_stamp, entry_valid;
//          |     |                    | tdata: out_stamp, out_tag; tlast: last
//  cfg     | in  | cfg_we             | cfg_wdata: keep_count
//
// Offer: accept, compare/insert across the row in ST_CMP, then the prune word
// loads in ST_FIN and the sequencer returns to ST_IDLE for the next input.
// Clear, zero stamp and empty readout load the word at accept.
// Readout rotates the row once, one word per cycle paced by m_tready.
// Input waits for an idle sequencer and a free or emptying output register.
// Synchronous reset empties the store; the keep count returns to 20.
`timescale 1ns / 1ps
`default_nettype none
module newest_n_keeper_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] stamp, [47:32] item_tag
  input  wire logic [7:0]  s_tuser,   // [1:0] req_type, [7:2] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] out_stamp, [47:32] out_tag
  output logic [7:0]       m_tuser,   // [0] prune, [1] bad_stamp, [2] entry_valid
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FIN,
    ST_READ
  } state_t;

  localparam int CW = nnk_pkg::CNT_W;

  state_t                       state;
  logic [nnk_pkg::KEEP_W-1:0]   keep_count;
  logic [CW-1:0]                count, count_next, keep_eff, rd_idx;
  logic [nnk_pkg::STAMP_W-1:0]  st_r;
  logic [nnk_pkg::TAG_W-1:0]    tg_r;
  logic                         full, early, do_insert, slot_free, rd_last;
  logic                         zero_offer, out_load;
  nnk_pkg::chain_ctl_t          ctl;
  nnk_pkg::chain_stat_t         stat;

  always_comb begin
    if (keep_count == '0) begin
      keep_eff = CW'(1);
    end else if (int'(keep_count) > nnk_pkg::CAPACITY) begin
      keep_eff = CW'(nnk_pkg::CAPACITY);
    end else begin
      keep_eff = CW'(keep_count);
    end
  end

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign full      = count == keep_eff;
  assign early     = full && (st_r < stat.oldest);
  assign do_insert = (state == ST_CMP) && !early && !stat.dup;
  assign count_next = full ? count : count + CW'(1);
  assign rd_last   = rd_idx == count - CW'(1);
  assign zero_offer = (s_tuser[1:0] == nnk_pkg::REQ_OFFER) && (s_tdata[31:0] == '0);

  // a word enters the output register this cycle
  assign out_load = (s_tvalid && s_tready &&
                     ((s_tuser[1:0] == nnk_pkg::REQ_CLEAR) || zero_offer ||
                      ((s_tuser[1:0] == nnk_pkg::REQ_READ) && (count == '0)))) ||
                    (((state == ST_FIN) || (state == ST_READ)) && slot_free);

  always_comb begin
    ctl.stamp = st_r;
    ctl.tag   = tg_r;
    ctl.count = count;
    if (do_insert) begin
      ctl.op = nnk_pkg::OP_INSERT;
    end else if (state == ST_READ && slot_free) begin
      ctl.op = nnk_pkg::OP_ROTATE;
    end else begin
      ctl.op = nnk_pkg::OP_HOLD;
    end
  end

  nnk_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= nnk_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            m_tdata <= '0;
            m_tuser <= {6'd0, zero_offer, 1'b0};
            m_tlast <= 1'b1;
            case (s_tuser[1:0])
              nnk_pkg::REQ_CLEAR: begin
                count <= '0;
              end
              nnk_pkg::REQ_OFFER: begin
                if (s_tdata[31:0] != '0) begin
                  st_r <= s_tdata[31:0];
                  tg_r <= s_tdata[47:32];
                  // a lowered keep count trims the oldest entries first
                  if (count > keep_eff) count <= keep_eff;
                  state <= ST_CMP;
                end
              end
              nnk_pkg::REQ_READ: begin
                if (count != '0) begin
                  rd_idx <= '0;
                  state  <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CMP: begin
          if (do_insert) count <= count_next;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (slot_free) begin
            m_tdata  <= '0;
            m_tuser  <= {7'd0, full && (st_r <= stat.oldest)};
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (slot_free) begin
            m_tdata  <= {stat.head_tag, stat.head_stamp};
            m_tuser  <= 8'd4;
            m_tlast  <= rd_last;
            rd_idx   <= rd_idx + CW'(1);
            if (rd_last) state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/newest_n_keeper_top_tb.sv =====
`timescale 1ns / 1ps
// newest_n_keeper_top_tb: self-checking bench for the newest-n keeper.
// Checks every response word against a sorted-store predictor kept in the bench.
// Depends on nnk_pkg and newest_n_keeper_top.
module newest_n_keeper_top_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CFG_SETTLE   = 8;

  typedef struct packed {
    logic                        prune;
    logic                        bad_stamp;
    logic                        entry_valid;
    logic [nnk_pkg::STAMP_W-1:0] stamp;
    logic [nnk_pkg::TAG_W-1:0]   tag;
    logic                        last;
  } keeper_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [31:0] stamp, [47:32] item_tag
  logic [7:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] out_stamp, [47:32] out_tag
  logic [7:0]  m_tuser;        // [0] prune, [1] bad_stamp, [2] entry_valid
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;

  // bench copy of the store
  logic [nnk_pkg::STAMP_W-1:0] store_stamps [nnk_pkg::CAPACITY];
  logic [nnk_pkg::TAG_W-1:0]   store_tags [nnk_pkg::CAPACITY];
  int                          store_fill;
  logic [nnk_pkg::STAMP_W-1:0] store_oldest;
  logic [nnk_pkg::KEEP_W-1:0]  keep_reg;

  keeper_word_t expected_words [$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           send_idle = 0;
  int           recv_idle = 0;
  logic         stall_kick = 1'b0;
  logic         stall_seen;
  int           stall_left;

  newest_n_keeper_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void update_oldest();
    store_oldest = (store_fill > 0) ? store_stamps[store_fill-1] : '0;
  endfunction

  // insert one stamp into the sorted store, return the prune flag
  function automatic logic offer_outcome(input logic [nnk_pkg::STAMP_W-1:0] stamp,
                                         input logic [nnk_pkg::TAG_W-1:0] tag);
    int   keep;
    int   pos;
    logic dup;
    if (keep_reg == '0) keep = 1;
    else if (int'(keep_reg) > nnk_pkg::CAPACITY) keep = nnk_pkg::CAPACITY;
    else keep = int'(keep_reg);
    // keep count lowered since the last offer: trim oldest first
    if (store_fill > keep) begin
      store_fill = keep;
      update_oldest();
    end
    if (store_fill == keep && stamp < store_oldest) return 1'b1;
    dup = 1'b0;
    for (int i = 0; i < store_fill; i++)
      if (store_stamps[i] == stamp) dup = 1'b1;
    if (!dup) begin
      if (store_fill >= keep) store_fill--;
      pos = 0;
      while (pos < store_fill && store_stamps[pos] > stamp) pos++;
      for (int i = store_fill; i > pos; i--) begin
        store_stamps[i] = store_stamps[i-1];
        store_tags[i]   = store_tags[i-1];
      end
      store_stamps[pos] = stamp;
      store_tags[pos]   = tag;
      store_fill++;
      update_oldest();
    end
    return (store_fill == keep && stamp <= store_oldest);
  endfunction

  function automatic void predict_words(input logic [1:0] req,
                                        input logic [nnk_pkg::STAMP_W-1:0] stamp,
                                        input logic [nnk_pkg::TAG_W-1:0] tag);
    keeper_word_t w;
    w = '0;
    w.last = 1'b1;
    case (req)
      nnk_pkg::REQ_CLEAR: begin
        store_fill   = 0;
        store_oldest = '0;
        expected_words.push_back(w);
      end
      nnk_pkg::REQ_OFFER: begin
        if (stamp == '0) w.bad_stamp = 1'b1;
        else w.prune = offer_outcome(stamp, tag);
        expected_words.push_back(w);
      end
      nnk_pkg::REQ_READ: begin
        if (store_fill == 0) expected_words.push_back(w);
        for (int i = 0; i < store_fill; i++) begin
          w.entry_valid = 1'b1;
          w.stamp       = store_stamps[i];
          w.tag         = store_tags[i];
          w.last        = (i + 1 == store_fill);
          expected_words.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  // one process sees config writes, accepted requests and accepted words in
  // a fixed order, so prediction always lands before the check
  always @(posedge clk) begin : monitor
    keeper_word_t got;
    keeper_word_t want;
    if (rst) begin
      store_fill   = 0;
      store_oldest = '0;
      keep_reg     = nnk_pkg::KEEP_RESET;
    end else begin
      if (cfg_we) keep_reg = cfg_wdata;
      if (s_tvalid && s_tready) predict_words(s_tuser[1:0], s_tdata[31:0], s_tdata[47:32]);
      if (m_tvalid && m_tready) begin
        got.prune       = m_tuser[0];
        got.bad_stamp   = m_tuser[1];
        got.entry_valid = m_tuser[2];
        got.stamp       = m_tdata[31:0];
        got.tag         = m_tdata[47:32];
        got.last        = m_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word prune=%0b bad=%0b valid=%0b stamp=%h tag=%h last=%0b",
                   $time, got.prune, got.bad_stamp, got.entry_valid, got.stamp, got.tag,
                   got.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.prune !== want.prune || got.bad_stamp !== want.bad_stamp ||
              got.entry_valid !== want.entry_valid || got.stamp !== want.stamp ||
              got.tag !== want.tag || got.last !== want.last) begin
            $display("%0t: mismatch expected prune=%0b bad=%0b valid=%0b stamp=%h tag=%h last=%0b",
                     $time, want.prune, want.bad_stamp, want.entry_valid, want.stamp,
                     want.tag, want.last);
            $display("%0t:          actual   prune=%0b bad=%0b valid=%0b stamp=%h tag=%h last=%0b",
                     $time, got.prune, got.bad_stamp, got.entry_valid, got.stamp, got.tag,
                     got.last);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: random backpressure, plus a long hold-off on each kick
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_seen <= 1'b0;
      stall_left <= 0;
    end else if (stall_seen != stall_kick) begin
      stall_seen <= stall_kick;
      stall_left <= STALL_CYCLES;
      m_tready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("newest_n_keeper_top_tb: FAIL");
      $finish;
    end
  end

  // leaves tvalid high so back-to-back words need no extra edge
  task automatic send_request(input logic [1:0] req,
                              input logic [nnk_pkg::STAMP_W-1:0] stamp,
                              input logic [nnk_pkg::TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {6'd0, req};
    s_tdata  <= {tag, stamp};
    do @(posedge clk); while (!s_tready);
  endtask

  // write keep_count once the block has gone quiet; the first edge lets the
  // monitor log the last accepted request
  task automatic set_keep(input logic [nnk_pkg::KEEP_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_basic_requests();
    send_request(nnk_pkg::REQ_READ, $urandom, 16'($urandom_range(16'hFFFF)));
    send_request(nnk_pkg::REQ_OFFER, 32'd0, 16'hFFFF);
    send_request(nnk_pkg::REQ_OFFER, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(nnk_pkg::REQ_OFFER, 32'd1, 16'h0000);
    send_request(nnk_pkg::REQ_OFFER, 32'hFFFF_FFFF, 16'h1234);  // duplicate keeps old tag
    send_request(nnk_pkg::REQ_OFFER, 32'h8000_0000, 16'h8001);
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(nnk_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(nnk_pkg::REQ_READ, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_keep_extremes();
    set_keep(6'd1);
    send_request(nnk_pkg::REQ_OFFER, 32'd50, 16'h0050);
    send_request(nnk_pkg::REQ_OFFER, 32'd40, 16'h0040);   // below oldest while full
    send_request(nnk_pkg::REQ_OFFER, 32'd50, 16'h0051);
    send_request(nnk_pkg::REQ_OFFER, 32'd60, 16'h0060);
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
    set_keep(6'd0);
    send_request(nnk_pkg::REQ_OFFER, 32'd70, 16'h0070);
    send_request(nnk_pkg::REQ_OFFER, 32'd65, 16'h0065);
    set_keep(6'd63);
    send_request(nnk_pkg::REQ_OFFER, 32'd10, 16'h0010);
    send_request(nnk_pkg::REQ_OFFER, 32'd30, 16'h0030);
    send_request(nnk_pkg::REQ_OFFER, 32'd20, 16'h0020);
    send_request(nnk_pkg::REQ_OFFER, 32'd40, 16'h0040);
    // drop below the fill level: readout still lists all, next offer trims
    set_keep(6'd2);
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
    send_request(nnk_pkg::REQ_OFFER, 32'd35, 16'h0035);
    send_request(nnk_pkg::REQ_OFFER, 32'd45, 16'h0045);
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
  endtask

  task automatic test_random_traffic(input int count);
    int                          sent;
    int                          seg;
    int                          roll;
    logic [nnk_pkg::STAMP_W-1:0] feed_time;
    logic [nnk_pkg::STAMP_W-1:0] stamp;
    logic [nnk_pkg::KEEP_W-1:0]  keep_pick;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0:       keep_pick = 6'd0;
        1:       keep_pick = 6'd1;
        2:       keep_pick = 6'd2;
        3:       keep_pick = 6'd32;
        4:       keep_pick = 6'd63;
        5:       keep_pick = 6'd33;
        default: keep_pick = 6'($urandom_range(1, nnk_pkg::CAPACITY));
      endcase
      set_keep(keep_pick);
      feed_time = $urandom;
      if ($urandom_range(1) == 0) begin
        send_request(nnk_pkg::REQ_CLEAR, $urandom, 16'($urandom_range(16'hFFFF)));
        sent++;
      end
      // one feed scan: mostly offers clustered around a moving time
      for (seg = 0; seg < 50 && sent < count; seg++) begin
        roll = $urandom_range(99);
        if (roll < 2) begin
          send_request(nnk_pkg::REQ_CLEAR, $urandom, 16'($urandom_range(16'hFFFF)));
          sent++;
        end else if (roll < 4) begin
          send_request(REQ_UNUSED, $urandom, 16'($urandom_range(16'hFFFF)));
        end else if (roll < 14) begin
          send_request(nnk_pkg::REQ_READ, $urandom, 16'($urandom_range(16'hFFFF)));
          sent++;
        end else begin
          feed_time = feed_time + $urandom_range(6);
          roll = $urandom_range(99);
          if (roll < 3) stamp = '0;
          else if (roll < 8) stamp = $urandom;
          else if (roll < 10) stamp = 32'hFFFF_FFFF - $urandom_range(3);
          else stamp = feed_time - $urandom_range(48);
          send_request(nnk_pkg::REQ_OFFER, stamp, 16'($urandom_range(16'hFFFF)));
          sent++;
        end
      end
    end
  endtask

  // receiver holds off while offers and readouts keep coming
  task automatic test_output_stall();
    logic [nnk_pkg::STAMP_W-1:0] feed_time;
    set_keep(6'd32);
    feed_time = $urandom;
    stall_kick <= ~stall_kick;
    for (int i = 0; i < 14; i++)
      send_request(nnk_pkg::REQ_OFFER, feed_time + $urandom_range(40),
                   16'($urandom_range(16'hFFFF)));
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
    for (int i = 0; i < 4; i++)
      send_request(nnk_pkg::REQ_OFFER, feed_time + $urandom_range(40),
                   16'($urandom_range(16'hFFFF)));
    send_request(nnk_pkg::REQ_READ, 32'd0, 16'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle = 6;
    recv_idle <= 79;
    test_basic_requests();
    test_keep_extremes();
    test_random_traffic(140);
    send_idle = 79;
    recv_idle <= 6;
    test_random_traffic(140);
    send_idle = 0;
    recv_idle <= 0;
    test_random_traffic(140);
    test_output_stall();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("newest_n_keeper_top_tb: PASS");
    else
      $display("newest_n_keeper_top_tb: FAIL");
    $finish;
  end

endmodule
